/* rtl/core/anxb_pkg.sv */
// Shared types and constants for the Annex B NAL splitter.
package anxb_pkg;

    // Bytes held in the look-ahead window while one item is worked on.
    localparam int WIN = 5;
    // Bytes that stay in the window between items.
    localparam int LA_DEPTH = WIN - 1;
    // Most results one item can cause (one from the scan, four from a flush).
    localparam int MAX_RES = 5;
    localparam int RES_IDX_W = $clog2(MAX_RES + 1);

    // Records held between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [4:0] unit_type;
        logic [1:0] ref_idc;
        logic [7:0] payload_byte;
        logic       last_of_unit;
    } result_t;

    // All results caused by one input item, oldest in res[0].
    typedef struct packed {
        logic [RES_IDX_W-1:0]       count;
        result_t [MAX_RES-1:0]      res;
    } record_t;

endpackage

/* rtl/core/anxb_front.sv */
// Front end: start code scan and NAL framing, one input item per cycle while the queue is not full.
module anxb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_end_of_stream,
    input  logic              q_full,
    output logic              push,
    output anxb_pkg::record_t push_rec
);
    import anxb_pkg::*;

    localparam logic [1:0] MODE_SEARCH    = 2'd0;
    localparam logic [1:0] MODE_HDR_NEW   = 2'd1;
    localparam logic [1:0] MODE_HDR_PEND  = 2'd2;
    localparam logic [1:0] MODE_BYTE_PEND = 2'd3;

    // Enough passes to cover emit -> search -> skip start code -> wait.
    localparam int STEP_ITERS = 4;

    typedef logic [WIN-1:0][7:0] window_t;

    logic [LA_DEPTH-1:0][7:0] la_reg, la_next;
    logic [2:0]               fill_reg, fill_next;
    logic [1:0]               mode_reg, mode_next;
    record_t                  rec;
    logic                     accept;

    function automatic result_t make_result(input logic kind, input logic [7:0] b,
                                            input logic last);
        result_t r;
        r = '0;
        r.kind = kind;
        r.last_of_unit = last;
        if (kind == KIND_HEADER) begin
            r.unit_type = b[4:0];
            r.ref_idc   = b[6:5];
        end else begin
            r.payload_byte = b;
        end
        return r;
    endfunction

    // 00 00 01 or 00 00 00 01 starting at b0.
    function automatic logic is_start(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
        return (b0 == 8'd0) && (b1 == 8'd0) &&
               ((b2 == 8'd1) || ((b2 == 8'd0) && (b3 == 8'd1)));
    endfunction

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign push     = accept && (rec.count != '0);
    assign push_rec = rec;

    always_comb begin : step_comb
        window_t                w;
        logic [2:0]             fill;
        logic [1:0]             md;
        logic                   done;
        logic                   last;
        logic [RES_IDX_W-1:0]   n;

        w = '0;
        for (int i = 0; i < LA_DEPTH; i++) begin
            w[i] = la_reg[i];
        end
        w[fill_reg] = s_data_byte;
        fill = fill_reg + 3'd1;
        md   = mode_reg;
        done = 1'b0;
        last = 1'b0;
        n    = '0;
        rec  = '0;

        for (int it = 0; it < STEP_ITERS; it++) begin
            if (!done) begin
                unique case (md)
                    MODE_SEARCH: begin
                        if (fill < 3'd4) begin
                            done = 1'b1;
                        end else if (w[0] == 8'd0 && w[1] == 8'd0 &&
                                     w[2] == 8'd0 && w[3] == 8'd1) begin
                            if (fill < 3'd5) begin
                                done = 1'b1;
                            end else begin
                                w    = w >> 32;
                                fill = fill - 3'd4;
                                md   = MODE_HDR_NEW;
                            end
                        end else if (w[0] == 8'd0 && w[1] == 8'd0 && w[2] == 8'd1) begin
                            w    = w >> 24;
                            fill = fill - 3'd3;
                            md   = MODE_HDR_NEW;
                        end else begin
                            w    = w >> 8;
                            fill = fill - 3'd1;
                        end
                    end
                    MODE_HDR_NEW: begin
                        if (fill < 3'd4) begin
                            done = 1'b1;
                        end else if (is_start(w[0], w[1], w[2], w[3])) begin
                            // header byte opens a start code: empty unit
                            rec.res[n] = make_result(KIND_HEADER, w[0], 1'b1);
                            n  = n + 1'b1;
                            md = MODE_SEARCH;
                        end else begin
                            md = MODE_HDR_PEND;
                        end
                    end
                    MODE_HDR_PEND, MODE_BYTE_PEND: begin
                        if (fill < 3'd5) begin
                            done = 1'b1;
                        end else begin
                            last = is_start(w[1], w[2], w[3], w[4]);
                            rec.res[n] = make_result(
                                (md == MODE_BYTE_PEND) ? KIND_PAYLOAD : KIND_HEADER,
                                w[0], last);
                            n    = n + 1'b1;
                            w    = w >> 8;
                            fill = fill - 3'd1;
                            md   = last ? MODE_SEARCH : MODE_BYTE_PEND;
                        end
                    end
                endcase
            end
        end

        if (s_end_of_stream) begin
            // flush whatever the open unit still holds
            if (md != MODE_SEARCH && fill != 3'd0) begin
                for (int k = 0; k < WIN; k++) begin
                    if (3'(k) < fill) begin
                        rec.res[n] = make_result(
                            (k == 0 && md != MODE_BYTE_PEND) ? KIND_HEADER : KIND_PAYLOAD,
                            w[k], 3'(k + 1) == fill);
                        n = n + 1'b1;
                    end
                end
            end
            la_next   = '0;
            fill_next = '0;
            mode_next = MODE_SEARCH;
        end else begin
            la_next   = w[LA_DEPTH-1:0];
            fill_next = fill;
            mode_next = md;
        end
        rec.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_reg   <= '0;
            fill_reg <= '0;
            mode_reg <= MODE_SEARCH;
        end else if (accept) begin
            la_reg   <= la_next;
            fill_reg <= fill_next;
            mode_reg <= mode_next;
        end
    end

endmodule

/* rtl/core/anxb_queue.sv */
// Record queue between the front end and the output sequencer.
module anxb_queue #(
    parameter int DEPTH = anxb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  anxb_pkg::record_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output anxb_pkg::record_t head_rec
);
    import anxb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    record_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/anxb_back.sv */
// Back end: walks each record and drives the registered result channel.
module anxb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  anxb_pkg::record_t head_rec,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [4:0]        m_unit_type,
    output logic [1:0]        m_ref_idc,
    output logic [7:0]        m_payload_byte,
    output logic              m_last_of_unit
);
    import anxb_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    logic                 load;
    logic                 at_last;

    assign load    = head_valid && (!out_valid_reg || m_ready);
    assign at_last = (idx_reg == head_rec.count - 1'b1);
    assign pop     = load && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= head_rec.res[idx_reg];
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_unit_type    = out_reg.unit_type;
    assign m_ref_idc      = out_reg.ref_idc;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_last_of_unit = out_reg.last_of_unit;

endmodule

/* rtl/core/annexb_nal_splitter_core.sv */
// Annex B NAL splitter: top level tying front end, record queue and back end.
//
// Input channel (s_*): one stream byte per item, s_end_of_stream on the last one.
// Result channel (m_*): one header or payload result per item. A header result
// carries unit_type and ref_idc, a payload result carries payload_byte, and
// m_last_of_unit marks the final result of each NAL unit.
//
// A result caused by an input item is written into the record queue at the edge
// that accepts the item, then loaded into the output register, which drives
// m_valid and the result fields.
// Throughput: one input item per cycle while the queue has room. An ordinary byte
// causes at most one result; an end-of-stream byte causes up to five, which the back
// end sends one per cycle while m_ready is high, as the front end keeps taking items.
// The single output register sets the rate: one result per cycle while m_ready is high.
//
// When the receiver stalls, the output register holds its result, records
// collect in the queue (QUEUE_DEPTH records), and s_ready drops once it is full.
// Reset (aresetn low at a clock edge) empties the queue and output register
// and returns the parser to start code search with an empty window.
module annexb_nal_splitter_core #(
    parameter int QUEUE_DEPTH = anxb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [4:0] m_unit_type,
    output logic [1:0] m_ref_idc,
    output logic [7:0] m_payload_byte,
    output logic       m_last_of_unit
);
    import anxb_pkg::*;

    logic    push, q_full, pop, head_valid;
    record_t push_rec, head_rec;

    // front end: window, mode and the scan for start codes
    anxb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .q_full          (q_full),
        .push            (push),
        .push_rec        (push_rec)
    );

    // only items that cause results leave a record
    anxb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // back end: one result per cycle into the output register while it is free or taken
    anxb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_rec       (head_rec),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_unit_type    (m_unit_type),
        .m_ref_idc      (m_ref_idc),
        .m_payload_byte (m_payload_byte),
        .m_last_of_unit (m_last_of_unit)
    );

endmodule

/* rtl/core/anxb_checker.sv */
// Port-level checks on the NAL splitter, bound to the top level.
module anxb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic [4:0] m_unit_type,
    input logic [1:0] m_ref_idc,
    input logic [7:0] m_payload_byte,
    input logic       m_last_of_unit
);
    import anxb_pkg::*;

    // set between a header without last and the unit's final result
    logic in_unit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_unit_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (m_last_of_unit) begin
                in_unit_reg <= 1'b0;
            end else if (m_kind == KIND_HEADER) begin
                in_unit_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_kind, m_unit_type, m_ref_idc, m_payload_byte, m_last_of_unit}))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not empty after reset");

    a_payload_in_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_PAYLOAD |-> in_unit_reg)
        else $error("payload result outside a unit");

    a_header_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_HEADER |-> !in_unit_reg)
        else $error("header result before previous unit ended");

    a_field_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_HEADER && m_payload_byte == 8'd0) ||
                    (m_kind == KIND_PAYLOAD && m_unit_type == 5'd0 && m_ref_idc == 2'd0))
        else $error("unused result fields not zero");

endmodule

bind annexb_nal_splitter_core anxb_checker u_anxb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kind          (m_kind),
    .m_unit_type     (m_unit_type),
    .m_ref_idc       (m_ref_idc),
    .m_payload_byte  (m_payload_byte),
    .m_last_of_unit  (m_last_of_unit)
);

/* dv/annexb_nal_splitter_checker.sv */
// Result checker for the Annex B NAL splitter: tracks the parser and compares every result.
module annexb_nal_splitter_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_stream,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_kind,
    input  logic [4:0] m_unit_type,
    input  logic [1:0] m_ref_idc,
    input  logic [7:0] m_payload_byte,
    input  logic       m_last_of_unit,
    output int         outstanding,
    output int         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import anxb_pkg::*;

    localparam int unsigned MAX_ITEM_RESULTS = 6;
    localparam int unsigned PRINT_CAP        = 40;

    typedef enum logic [1:0] {
        SCAN_SEARCH,
        SCAN_HDR_NEW,
        SCAN_HDR_WAIT,
        SCAN_BYTE_WAIT
    } scan_mode_e;

    logic [7:0]  win_bytes [WIN];
    int unsigned win_fill;
    scan_mode_e  scan_mode;
    int unsigned item_results;
    result_t     pending_results [$];
    int          errors = 0;

    task automatic flag_mismatch(input string what);
        if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic void clear_window();
        foreach (win_bytes[i]) win_bytes[i] = 8'h00;
        win_fill = 0;
        scan_mode = SCAN_SEARCH;
    endfunction

    function automatic void shift_out(int unsigned k);
        if (k > win_fill) k = win_fill;
        for (int p = 0; p < WIN; p++)
            win_bytes[p] = (p + k < WIN) ? win_bytes[p + k] : 8'h00;
        win_fill = win_fill - k;
    endfunction

    // Unit ends just before position p (needs p..p+3 held).
    function automatic bit unit_ends_at(int unsigned p);
        if (p + 3 >= win_fill || p + 3 >= WIN) return 1'b0;
        return win_bytes[p] == 8'h00 && win_bytes[p + 1] == 8'h00 &&
               (win_bytes[p + 2] == 8'h01 ||
                (win_bytes[p + 2] == 8'h00 && win_bytes[p + 3] == 8'h01));
    endfunction

    function automatic void push_result(logic kind, logic [7:0] b, logic last);
        result_t r;
        if (item_results >= MAX_ITEM_RESULTS) return;
        r = '0;
        r.kind = kind;
        if (kind == KIND_HEADER) begin
            r.unit_type = b[4:0];
            r.ref_idc   = b[6:5];
        end else begin
            r.payload_byte = b;
        end
        r.last_of_unit = last;
        pending_results.insert(pending_results.size(), r);
        item_results++;
    endfunction

    function automatic void advance_parser(logic [7:0] b, logic eos);
        bit   busy;
        bit   last;
        logic first_kind;
        item_results = 0;
        if (win_fill >= WIN) shift_out(1);
        win_bytes[win_fill] = b;
        win_fill++;
        busy = 1'b1;
        while (busy) begin
            case (scan_mode)
                SCAN_SEARCH: begin
                    if (win_fill < 4) begin
                        busy = 1'b0;
                    end else if (win_bytes[0] == 8'h00 && win_bytes[1] == 8'h00 &&
                                 win_bytes[2] == 8'h00 && win_bytes[3] == 8'h01) begin
                        if (win_fill < 5) begin
                            busy = 1'b0;
                        end else begin
                            shift_out(4);
                            scan_mode = SCAN_HDR_NEW;
                        end
                    end else if (win_bytes[0] == 8'h00 && win_bytes[1] == 8'h00 &&
                                 win_bytes[2] == 8'h01) begin
                        shift_out(3);
                        scan_mode = SCAN_HDR_NEW;
                    end else begin
                        shift_out(1);
                    end
                end
                SCAN_HDR_NEW: begin
                    if (win_fill < 4) begin
                        busy = 1'b0;
                    end else if (unit_ends_at(0)) begin
                        // header byte opens a start code: empty unit, rescan from it
                        push_result(KIND_HEADER, win_bytes[0], 1'b1);
                        scan_mode = SCAN_SEARCH;
                    end else begin
                        scan_mode = SCAN_HDR_WAIT;
                    end
                end
                default: begin
                    if (win_fill < 5) begin
                        busy = 1'b0;
                    end else begin
                        last = unit_ends_at(1);
                        push_result((scan_mode == SCAN_BYTE_WAIT) ? KIND_PAYLOAD : KIND_HEADER,
                                    win_bytes[0], last);
                        shift_out(1);
                        scan_mode = last ? SCAN_SEARCH : SCAN_BYTE_WAIT;
                    end
                end
            endcase
        end
        if (eos) begin
            if (scan_mode != SCAN_SEARCH && win_fill > 0) begin
                first_kind = (scan_mode == SCAN_BYTE_WAIT) ? KIND_PAYLOAD : KIND_HEADER;
                for (int k = 0; k < win_fill && k < WIN; k++)
                    push_result((k == 0) ? first_kind : KIND_PAYLOAD, win_bytes[k],
                                k + 1 == win_fill);
            end
            clear_window();
        end
    endfunction

    // A result is queued and then registered after its cause, so compare before predicting.
    always @(posedge aclk) begin : track
        result_t want;
        if (!aresetn) begin
            pending_results.delete();
            clear_window();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind=%0d byte=%02h",
                                            m_kind, m_payload_byte));
                end else begin
                    want = pending_results.pop_front();
                    if (m_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
                    if (m_unit_type !== want.unit_type)
                        flag_mismatch($sformatf("unit_type %0d, want %0d",
                                                m_unit_type, want.unit_type));
                    if (m_ref_idc !== want.ref_idc)
                        flag_mismatch($sformatf("ref_idc %0d, want %0d",
                                                m_ref_idc, want.ref_idc));
                    if (m_payload_byte !== want.payload_byte)
                        flag_mismatch($sformatf("payload_byte %02h, want %02h",
                                                m_payload_byte, want.payload_byte));
                    if (m_last_of_unit !== want.last_of_unit)
                        flag_mismatch($sformatf("last_of_unit %0d, want %0d",
                                                m_last_of_unit, want.last_of_unit));
                end
            end
            if (s_valid && s_ready) advance_parser(s_data_byte, s_end_of_stream);
        end
        outstanding <= pending_results.size();
        fail_count  <= errors;
    end

endmodule

/* dv/annexb_nal_splitter_core_tb.sv */
// Top-level testbench for the Annex B NAL splitter: stimulus, flow control and verdict.
module annexb_nal_splitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_BUDGET  = 300;  // stream bytes in all, roughly
    localparam int unsigned STALL_LIMIT  = 2000; // cycles without any handshake
    localparam int unsigned DRAIN_CYCLES = 8;    // idle cycles for stray results after the drain; leave slack

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_end_of_stream;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic [4:0] m_unit_type;
    logic [1:0] m_ref_idc;
    logic [7:0] m_payload_byte;
    logic       m_last_of_unit;

    int          fail_count;
    int          outstanding;
    int unsigned tx_calm;
    int unsigned rx_calm;
    int unsigned items_sent;
    logic [7:0]  stream_bytes [$];   // bytes of the stream being built, eos on the last

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    annexb_nal_splitter_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_unit_type     (m_unit_type),
        .m_ref_idc       (m_ref_idc),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_unit  (m_last_of_unit)
    );

    annexb_nal_splitter_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_unit_type     (m_unit_type),
        .m_ref_idc       (m_ref_idc),
        .m_payload_byte  (m_payload_byte),
        .m_last_of_unit  (m_last_of_unit),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    // Wait before the next item: drawn uniformly, with occasional back-to-back stretches.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Appends one byte to the stream being built.
    function automatic void append_byte(logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    // Skewed toward 00 and 01 so start codes turn up inside payloads and noise.
    function automatic logic [7:0] pick_stream_byte();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return 8'h00;
        if (roll == 2) return 8'h01;
        return 8'($urandom);
    endfunction

    // 3- or 4-byte start code, sometimes behind a short run of extra zeros.
    function automatic void add_start_code();
        int unsigned extra;
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) append_byte(8'h00);
        if ($urandom_range(0, 1) == 1) append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h01);
    endfunction

    // Start code, header byte and 0..8 payload bytes. A zero header with an
    // empty or zero-led payload exercises the header-opens-start-code case.
    function automatic void add_unit();
        int unsigned len;
        add_start_code();
        append_byte(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
        len = $urandom_range(0, 8);
        repeat (len) append_byte(pick_stream_byte());
    endfunction

    function automatic void build_wellformed();
        int unsigned junk;
        int unsigned units;
        junk  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        units = $urandom_range(1, 4);
        repeat (junk) append_byte(pick_stream_byte());
        repeat (units) add_unit();
    endfunction

    // One item: hold valid and payload steady until the edge that takes it.
    // Entered and left at a falling edge, so each input changes once per step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data_byte     = b;
        s_end_of_stream = eos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_stream();
        while (stream_bytes.size() > 0) begin
            send_byte(stream_bytes[0], stream_bytes.size() == 1);
            void'(stream_bytes.pop_front());
        end
    endtask

    // Result side: random stall before each result, then ready until one is taken.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        rx_calm = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Hang detection: any handshake on either side restarts the count.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned cut;
        s_valid         = 1'b0;
        s_data_byte     = 8'h00;
        s_end_of_stream = 1'b0;
        aresetn         = 1'b0;
        tx_calm         = 0;
        items_sent      = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: 4-byte code, header FF (type 31, ref 3), payload 00 FF ahead of a
        // 3-byte code, header 00 that opens a start code (empty unit), then header 1F
        // and payload 80 flushed at end of stream.
        stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00,
                         8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h80};
        send_stream();
        // A start code sitting in the last three bytes is flushed as payload.
        stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
        send_stream();
        // Start code with no header byte after it: nothing comes out.
        stream_bytes = '{8'h00, 8'h00, 8'h01};
        send_stream();

        // Random streams: mostly well formed, some noise, some cut short, some bare start codes.
        while (items_sent < ITEM_BUDGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                build_wellformed();
            end else if (pick < 16) begin
                repeat ($urandom_range(1, 10)) append_byte(pick_stream_byte());
            end else if (pick < 19) begin
                build_wellformed();
                cut = $urandom_range(1, stream_bytes.size());
                while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
            end else begin
                add_start_code();
            end
            send_stream();
        end
        s_valid = 1'b0;

        // Drain: all expected results in, then DRAIN_CYCLES idle cycles for strays.
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/anxb_pkg.sv
rtl/core/anxb_front.sv
rtl/core/anxb_queue.sv
rtl/core/anxb_back.sv
rtl/core/annexb_nal_splitter_core.sv
rtl/core/anxb_checker.sv
dv/annexb_nal_splitter_checker.sv
dv/annexb_nal_splitter_core_tb.sv
